### src/acx_pkg.sv
package acx_pkg;

   localparam int CSR_ADDR_W = 4;
   localparam int TERM_LAST  = 17;
   localparam int EXP_LAT    = 4 + 4 * (TERM_LAST - 1) + 1;
   localparam int N_W        = 23;

   localparam logic [31:0] RESET_A = 32'd167772;
   localparam logic [31:0] RESET_B = 32'd26843546;
   localparam logic [31:0] RESET_C = 32'd83886;
   localparam logic [31:0] RESET_D = 32'd16777216;

   localparam logic [32:0] LOG2E_Q32 = 33'h171547653;
   localparam logic [59:0] LN2_Q60   = 60'hB17217F7D1CF79B;
   localparam logic [63:0] ONE_Q60   = 64'h1000_0000_0000_0000;
   localparam logic [63:0] MAX47     = 64'h0000_7FFF_FFFF_FFFF;
   localparam logic [47:0] OUT_MAX   = 48'h7FFF_FFFF_FFFF;
   localparam logic [47:0] OUT_MIN   = 48'h8000_0000_0000;

   typedef enum logic [1:0] {
      CSR_AMPLITUDE_A = 2'd0,
      CSR_RATE_B      = 2'd1,
      CSR_COUPLING_C  = 2'd2,
      CSR_WIDTH_D     = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [31:0] amplitude_a;
      logic [31:0] rate_b;
      logic [31:0] coupling_c;
      logic [31:0] width_d;
   } cfg_type;

   typedef struct packed {
      logic        neg;
      logic        inf;
      logic [63:0] mag;
   } wv_type;

   typedef struct packed {
      logic        neg;
      logic [31:0] mag;
   } abs_type;

   typedef struct packed {
      logic        sat;
      logic [47:0] value;
   } emit_type;

   localparam wv_type WV_ONE = '{neg: 1'b0, inf: 1'b0, mag: 64'h1_0000_0000};

   function automatic abs_type sabs32(logic [31:0] v);
      abs_type r;
      r.neg = v[31];
      r.mag = v[31] ? (~v + 32'd1) : v;
      return r;
   endfunction

   function automatic wv_type neg_wv(wv_type a);
      wv_type r;
      r = a;
      if (a.inf || a.mag != 64'd0) r.neg = ~a.neg;
      return r;
   endfunction

   function automatic wv_type dbl_wv(wv_type a);
      wv_type r;
      r = a;
      if (!a.inf) begin
         if (a.mag[63]) begin
            r.inf = 1'b1;
            r.mag = '1;
         end else begin
            r.mag = {a.mag[62:0], 1'b0};
         end
      end
      return r;
   endfunction

   function automatic wv_type add_wv(wv_type a, wv_type b);
      wv_type     r;
      logic [64:0] s;
      r = '0;
      s = {1'b0, a.mag} + {1'b0, b.mag};
      if (a.inf) begin
         r = a;
      end else if (b.inf) begin
         r = b;
      end else begin
         if (a.neg == b.neg) begin
            r.neg = a.neg;
            if (s[64]) begin
               r.inf = 1'b1;
               r.mag = '1;
            end else begin
               r.mag = s[63:0];
            end
         end else if (a.mag >= b.mag) begin
            r.mag = a.mag - b.mag;
            r.neg = a.neg;
         end else begin
            r.mag = b.mag - a.mag;
            r.neg = b.neg;
         end
         if (!r.inf && r.mag == 64'd0) r.neg = 1'b0;
      end
      return r;
   endfunction

   function automatic emit_type emit_wv(wv_type v);
      emit_type    r;
      logic [63:0] m;
      r.sat = 1'b0;
      m = v.inf ? '1 : v.mag;
      if (!v.neg && m > MAX47) begin
         m = MAX47;
         r.sat = 1'b1;
      end
      if (v.neg && m > MAX47 + 64'd1) begin
         m = MAX47 + 64'd1;
         r.sat = 1'b1;
      end
      m = v.neg ? (64'd0 - m) : m;
      r.value = m[47:0];
      return r;
   endfunction

endpackage

### src/acx_csr.sv
module acx_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [acx_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [31:0]                      pwdata,
   output logic [31:0]                      prdata,
   output logic                             pready,
   output acx_pkg::cfg_type                 cfg
);

   acx_pkg::cfg_type      cfg_ff;
   acx_pkg::csr_index_type idx;
   logic                  wr;

   assign idx    = acx_pkg::csr_index_type'(paddr[3:2]);
   assign wr     = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.amplitude_a <= acx_pkg::RESET_A;
         cfg_ff.rate_b      <= acx_pkg::RESET_B;
         cfg_ff.coupling_c  <= acx_pkg::RESET_C;
         cfg_ff.width_d     <= acx_pkg::RESET_D;
      end else if (wr) begin
         case (idx)
            acx_pkg::CSR_AMPLITUDE_A: cfg_ff.amplitude_a <= pwdata;
            acx_pkg::CSR_RATE_B:      cfg_ff.rate_b      <= pwdata;
            acx_pkg::CSR_COUPLING_C:  cfg_ff.coupling_c  <= pwdata;
            acx_pkg::CSR_WIDTH_D:     cfg_ff.width_d     <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         acx_pkg::CSR_AMPLITUDE_A: prdata = cfg_ff.amplitude_a;
         acx_pkg::CSR_RATE_B:      prdata = cfg_ff.rate_b;
         acx_pkg::CSR_COUPLING_C:  prdata = cfg_ff.coupling_c;
         acx_pkg::CSR_WIDTH_D:     prdata = cfg_ff.width_d;
         default:                  prdata = 32'd0;
      endcase
   end

endmodule

### src/acx_delay.sv
module acx_delay #(
   parameter int W     = 32,
   parameter int DEPTH = 1
) (
   input  logic         clock,
   input  logic         en,
   input  logic [W-1:0] d,
   output logic [W-1:0] q
);

   logic [W-1:0] pipe_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         pipe_ff[0] <= d;
         for (int i = 1; i < DEPTH; i++) pipe_ff[i] <= pipe_ff[i-1];
      end
   end

   assign q = pipe_ff[DEPTH-1];

endmodule

### src/acx_mulr.sv
module acx_mulr (
   input  logic            clock,
   input  logic            reset,
   input  logic            en,
   input  logic            in_valid,
   input  acx_pkg::wv_type a,
   input  logic [31:0]     raw,
   output logic            out_valid,
   output acx_pkg::wv_type r
);

   acx_pkg::abs_type ra;
   logic             zero_in;
   logic             v1_ff, v2_ff;
   logic [63:0]      pl_ff, ph_ff;
   logic             neg_ff, inf_ff, zero_ff;
   logic [95:0]      full;
   logic             ov;
   acx_pkg::wv_type  r_in, r_ff;

   assign ra      = acx_pkg::sabs32(raw);
   assign zero_in = (ra.mag == 32'd0) || (!a.inf && a.mag == 64'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pl_ff   <= 64'(a.mag[31:0]) * 64'(ra.mag);
         ph_ff   <= 64'(a.mag[63:32]) * 64'(ra.mag);
         neg_ff  <= a.neg ^ ra.neg;
         inf_ff  <= a.inf;
         zero_ff <= zero_in;
         r_ff    <= r_in;
      end
   end

   assign full = {32'd0, pl_ff} + {ph_ff, 32'd0};
   assign ov   = full[95:88] != 8'd0;

   always_comb begin
      r_in = '0;
      if (!zero_ff) begin
         r_in.neg = neg_ff;
         if (inf_ff || ov) begin
            r_in.inf = 1'b1;
            r_in.mag = '1;
         end else begin
            r_in.mag = full[87:24];
         end
      end
   end

   assign out_valid = v2_ff;
   assign r         = r_ff;

endmodule

### src/acx_exp.sv
module acx_exp (
   input  logic            clock,
   input  logic            reset,
   input  logic            en,
   input  logic            in_valid,
   input  logic            grow,
   input  logic [53:0]     m,
   output logic            out_valid,
   output acx_pkg::wv_type e
);

   localparam int TL = acx_pkg::TERM_LAST;

   typedef struct packed {
      logic                    grow;
      logic [acx_pkg::N_W-1:0] n;
      logic [63:0]             sum;
      logic [59:0]             rr;
      logic [59:0]             term;
   } term_stage_type;

   logic           e1_v_ff, e2_v_ff, e3_v_ff, f_v_ff;
   logic [64:0]    e1_pl_ff;
   logic [54:0]    e1_ph_ff;
   logic           e1_g_ff, e2_g_ff, e3_g_ff;
   logic [86:0]    yfull;
   logic [acx_pkg::N_W-1:0] e2_n_ff, e3_n_ff;
   logic [31:0]    e2_f_ff;
   logic [61:0]    e3_lo_ff, e3_hi_ff;
   logic [91:0]    rfull;
   term_stage_type rec_in;
   term_stage_type rec [1:TL];
   logic           rec_v [1:TL];
   acx_pkg::wv_type e_in, e_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         e1_v_ff  <= 1'b0;
         e2_v_ff  <= 1'b0;
         e3_v_ff  <= 1'b0;
         rec_v[1] <= 1'b0;
         f_v_ff   <= 1'b0;
      end else if (en) begin
         e1_v_ff  <= in_valid;
         e2_v_ff  <= e1_v_ff;
         e3_v_ff  <= e2_v_ff;
         rec_v[1] <= e3_v_ff;
         f_v_ff   <= rec_v[TL];
      end
   end

   assign yfull = {22'd0, e1_pl_ff} + {e1_ph_ff, 32'd0};
   assign rfull = {30'd0, e3_lo_ff} + {e3_hi_ff, 30'd0};

   always_comb begin
      rec_in.grow = e3_g_ff;
      rec_in.n    = e3_n_ff;
      rec_in.rr   = rfull[91:32];
      rec_in.term = rfull[91:32];
      rec_in.sum  = e3_g_ff ? (acx_pkg::ONE_Q60 + {4'd0, rfull[91:32]})
                            : (acx_pkg::ONE_Q60 - {4'd0, rfull[91:32]});
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e1_pl_ff <= 65'(m[31:0]) * 65'(acx_pkg::LOG2E_Q32);
         e1_ph_ff <= 55'(m[53:32]) * 55'(acx_pkg::LOG2E_Q32);
         e1_g_ff  <= grow;
         e2_n_ff  <= yfull[86:64];
         e2_f_ff  <= yfull[63:32];
         e2_g_ff  <= e1_g_ff;
         e3_lo_ff <= 62'(e2_f_ff) * 62'(acx_pkg::LN2_Q60[29:0]);
         e3_hi_ff <= 62'(e2_f_ff) * 62'(acx_pkg::LN2_Q60[59:30]);
         e3_n_ff  <= e2_n_ff;
         e3_g_ff  <= e2_g_ff;
         rec[1]   <= rec_in;
         e_ff     <= e_in;
      end
   end

   for (genvar gi = 2; gi <= TL; gi++) begin : g_term
      localparam int K  = gi;
      localparam int SH = 60 + $clog2(K);
      localparam logic [127:0] RECIP = ((128'd1 << SH) + 128'(K) - 128'd1) / 128'(K);
      localparam logic [31:0] RECIP_LO = RECIP[31:0];
      localparam logic [31:0] RECIP_HI = RECIP[63:32];

      logic           a_v_ff, b_v_ff, c_v_ff;
      term_stage_type a_s_ff, b_s_ff, c_s_ff;
      logic [59:0]    a_ll_ff, a_lh_ff, a_hl_ff, a_hh_ff;
      logic [119:0]   pfull;
      logic [59:0]    b_p_ff;
      logic [63:0]    c_ll_ff, c_lh_ff, c_hl_ff, c_hh_ff;
      logic [127:0]   qfull;
      logic [59:0]    q;
      term_stage_type d_in;

      assign pfull = {60'd0, a_ll_ff} + ({60'd0, a_lh_ff} << 30) + ({60'd0, a_hl_ff} << 30)
                   + {a_hh_ff, 60'd0};
      assign qfull = {64'd0, c_ll_ff} + ({64'd0, c_lh_ff} << 32) + ({64'd0, c_hl_ff} << 32)
                   + {c_hh_ff, 64'd0};
      assign q     = qfull[SH +: 60];

      always_comb begin
         d_in      = c_s_ff;
         d_in.term = q;
         if (c_s_ff.grow || (K % 2) == 0) d_in.sum = c_s_ff.sum + {4'd0, q};
         else d_in.sum = c_s_ff.sum - {4'd0, q};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            a_v_ff    <= 1'b0;
            b_v_ff    <= 1'b0;
            c_v_ff    <= 1'b0;
            rec_v[gi] <= 1'b0;
         end else if (en) begin
            a_v_ff    <= rec_v[gi-1];
            b_v_ff    <= a_v_ff;
            c_v_ff    <= b_v_ff;
            rec_v[gi] <= c_v_ff;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            a_s_ff  <= rec[gi-1];
            a_ll_ff <= 60'(rec[gi-1].term[29:0])  * 60'(rec[gi-1].rr[29:0]);
            a_lh_ff <= 60'(rec[gi-1].term[29:0])  * 60'(rec[gi-1].rr[59:30]);
            a_hl_ff <= 60'(rec[gi-1].term[59:30]) * 60'(rec[gi-1].rr[29:0]);
            a_hh_ff <= 60'(rec[gi-1].term[59:30]) * 60'(rec[gi-1].rr[59:30]);
            b_s_ff  <= a_s_ff;
            b_p_ff  <= pfull[119:60];
            c_s_ff  <= b_s_ff;
            c_ll_ff <= 64'(b_p_ff[31:0])  * 64'(RECIP_LO);
            c_lh_ff <= 64'(b_p_ff[31:0])  * 64'(RECIP_HI);
            c_hl_ff <= 64'(b_p_ff[59:32]) * 64'(RECIP_LO);
            c_hh_ff <= 64'(b_p_ff[59:32]) * 64'(RECIP_HI);
            rec[gi] <= d_in;
         end
      end
   end

   always_comb begin
      logic [63:0]             s;
      logic [acx_pkg::N_W-1:0] n;
      logic [acx_pkg::N_W-1:0] sh;
      logic                    ovf;
      s   = rec[TL].sum;
      n   = rec[TL].n;
      sh  = n - acx_pkg::N_W'(28);
      ovf = 1'b0;
      e_in = '0;
      if (!rec[TL].grow) begin
         if (n < acx_pkg::N_W'(36)) e_in.mag = s >> (n[5:0] + 6'd28);
      end else if (n <= acx_pkg::N_W'(28)) begin
         e_in.mag = s >> (5'd28 - n[4:0]);
      end else begin
         ovf = (sh >= acx_pkg::N_W'(4)) || (sh[1:0] == 2'd1 && s[63])
            || (sh[1:0] == 2'd2 && s[63:62] != 2'd0) || (sh[1:0] == 2'd3 && s[63:61] != 3'd0);
         if (ovf) begin
            e_in.inf = 1'b1;
            e_in.mag = '1;
         end else begin
            e_in.mag = s << sh[1:0];
         end
      end
   end

   assign out_valid = f_v_ff;
   assign e         = e_ff;

endmodule

### src/avoided_crossing_hamiltonian_eval.sv
// channel   | handshake                 | payload
// ----------+---------------------------+------------------------------------------
// request   | req_valid / req_stall     | req_coord_x (Q8.24)
// response  | rsp_valid / rsp_stall     | rsp_h_diag .. rsp_d2h_coup (Q16.32), saturated
// registers | psel penable pwrite pready| paddr, pwdata, prdata
//
// One transaction per cycle while the response is not stalled; the series recurrence in
// each exponential unit has sixteen terms of four stages each.
// Synchronous active-high reset clears every valid bit and loads the four registers with their reset values.
// A stalled response freezes the whole pipeline; req_stall follows it in the same cycle.
module avoided_crossing_hamiltonian_eval (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [31:0]             req_coord_x,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [47:0]             rsp_h_diag,
   output logic signed [47:0]             rsp_h_coup,
   output logic signed [47:0]             rsp_dh_diag,
   output logic signed [47:0]             rsp_dh_coup,
   output logic signed [47:0]             rsp_d2h_diag,
   output logic signed [47:0]             rsp_d2h_coup,
   output logic                           rsp_saturated,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [acx_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                    pwdata,
   output logic [31:0]                    prdata,
   output logic                           pready
);

   localparam int WV = $bits(acx_pkg::wv_type);

   acx_pkg::cfg_type cfg;
   logic             en;
   logic             rsp_valid_ff;

   logic             v_p0_ff, v_p1_ff, v_p2_ff, v_p3_ff;
   logic [31:0]      x_p0_ff, x_p1_ff, x_p2_ff, x_p3_ff;
   logic [47:0]      m1_p1_ff, m1_p2_ff;
   logic [38:0]      sq_p1_ff;
   logic [63:0]      ml_p2_ff;
   logic [38:0]      mh_p2_ff;
   logic [53:0]      m1_p3_ff, m2_p3_ff;
   acx_pkg::abs_type ax, ab, ad;
   logic [63:0]      pbx, pxx;
   logic [70:0]      m2full;

   logic             e1_valid, e2_valid;
   acx_pkg::wv_type  e1, e2, hd_ff;
   logic [31:0]      x_q2, x_q3, x_q6;

   acx_pkg::wv_type  h00m, ma, dh00, d2m, h01, um, t1m, vm, wm, zm;
   acx_pkg::wv_type  h00s, d2s, dh01, t1;
   acx_pkg::wv_type  h00_q11, dh00_q11, d2h00_q11, h01_q11, dh01_q11, t1_q10, dc_ff;
   logic             h01_v, u_v, v_v, w_v, z_v, v_q11_ff;

   acx_pkg::emit_type o_hd, o_hc, o_dd, o_dc, o_2d, o_2c;
   logic [47:0]      hd_o_ff, hc_o_ff, dd_o_ff, dc_o_ff, d2d_o_ff, d2c_o_ff;
   logic             sat_o_ff;

   assign en        = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !en;

   acx_csr u_csr (
      .clock, .reset, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
   );

   assign ax     = acx_pkg::sabs32(x_p0_ff);
   assign ab     = acx_pkg::sabs32(cfg.rate_b);
   assign ad     = acx_pkg::sabs32(cfg.width_d);
   assign pbx    = 64'(ab.mag) * 64'(ax.mag);
   assign pxx    = 64'(ax.mag) * 64'(ax.mag);
   assign m2full = {7'd0, ml_p2_ff} + {mh_p2_ff, 32'd0};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_p0_ff      <= 1'b0;
         v_p1_ff      <= 1'b0;
         v_p2_ff      <= 1'b0;
         v_p3_ff      <= 1'b0;
         v_q11_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         v_p0_ff      <= req_valid;
         v_p1_ff      <= v_p0_ff;
         v_p2_ff      <= v_p1_ff;
         v_p3_ff      <= v_p2_ff;
         v_q11_ff     <= z_v;
         rsp_valid_ff <= v_q11_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_p0_ff  <= req_coord_x;
         x_p1_ff  <= x_p0_ff;
         m1_p1_ff <= pbx[63:16];
         sq_p1_ff <= pxx[62:24];
         x_p2_ff  <= x_p1_ff;
         m1_p2_ff <= m1_p1_ff;
         ml_p2_ff <= 64'(ad.mag) * 64'(sq_p1_ff[31:0]);
         mh_p2_ff <= 39'(ad.mag) * 39'(sq_p1_ff[38:32]);
         x_p3_ff  <= x_p2_ff;
         m1_p3_ff <= {6'd0, m1_p2_ff};
         m2_p3_ff <= m2full[69:16];
         hd_ff    <= acx_pkg::add_wv(acx_pkg::WV_ONE, acx_pkg::neg_wv(e1));
         dc_ff    <= acx_pkg::neg_wv(acx_pkg::add_wv(t1_q10, acx_pkg::dbl_wv(zm)));
         hd_o_ff  <= o_hd.value;
         hc_o_ff  <= o_hc.value;
         dd_o_ff  <= o_dd.value;
         dc_o_ff  <= o_dc.value;
         d2d_o_ff <= o_2d.value;
         d2c_o_ff <= o_2c.value;
         sat_o_ff <= o_hd.sat | o_hc.sat | o_dd.sat | o_dc.sat | o_2d.sat | o_2c.sat;
      end
   end

   acx_exp u_exp_diag (
      .clock, .reset, .en, .in_valid(v_p3_ff), .grow(cfg.rate_b[31]), .m(m1_p3_ff),
      .out_valid(e1_valid), .e(e1)
   );

   acx_exp u_exp_coup (
      .clock, .reset, .en, .in_valid(v_p3_ff), .grow(cfg.width_d[31]), .m(m2_p3_ff),
      .out_valid(e2_valid), .e(e2)
   );

   acx_delay #(.W(32), .DEPTH(acx_pkg::EXP_LAT + 2)) u_dl_x2 (
      .clock, .en, .d(x_p3_ff), .q(x_q2)
   );
   acx_delay #(.W(32), .DEPTH(1)) u_dl_x3 (.clock, .en, .d(x_q2), .q(x_q3));
   acx_delay #(.W(32), .DEPTH(3)) u_dl_x6 (.clock, .en, .d(x_q3), .q(x_q6));

   acx_mulr u_m_h00 (
      .clock, .reset, .en, .in_valid(e1_valid), .a(hd_ff), .raw(cfg.amplitude_a),
      .out_valid(), .r(h00m)
   );
   acx_mulr u_m_ea (
      .clock, .reset, .en, .in_valid(e1_valid), .a(e1), .raw(cfg.amplitude_a),
      .out_valid(), .r(ma)
   );
   acx_mulr u_m_dh00 (
      .clock, .reset, .en, .in_valid(e1_valid), .a(ma), .raw(cfg.rate_b),
      .out_valid(), .r(dh00)
   );
   acx_mulr u_m_d2h00 (
      .clock, .reset, .en, .in_valid(e1_valid), .a(dh00), .raw(cfg.rate_b),
      .out_valid(), .r(d2m)
   );

   acx_mulr u_m_h01 (
      .clock, .reset, .en, .in_valid(e2_valid), .a(e2), .raw(cfg.coupling_c),
      .out_valid(h01_v), .r(h01)
   );
   acx_mulr u_m_u (
      .clock, .reset, .en, .in_valid(h01_v), .a(h01), .raw(x_q2),
      .out_valid(u_v), .r(um)
   );
   acx_mulr u_m_t1 (
      .clock, .reset, .en, .in_valid(h01_v), .a(h01), .raw(cfg.width_d),
      .out_valid(), .r(t1m)
   );
   acx_mulr u_m_v (
      .clock, .reset, .en, .in_valid(u_v), .a(um), .raw(cfg.width_d),
      .out_valid(v_v), .r(vm)
   );
   acx_mulr u_m_w (
      .clock, .reset, .en, .in_valid(v_v), .a(dh01), .raw(x_q6),
      .out_valid(w_v), .r(wm)
   );
   acx_mulr u_m_z (
      .clock, .reset, .en, .in_valid(w_v), .a(wm), .raw(cfg.width_d),
      .out_valid(z_v), .r(zm)
   );

   assign h00s = x_q3[31] ? acx_pkg::neg_wv(h00m) : h00m;
   assign d2s  = x_q6[31] ? d2m : acx_pkg::neg_wv(d2m);
   assign dh01 = acx_pkg::neg_wv(acx_pkg::dbl_wv(vm));
   assign t1   = acx_pkg::dbl_wv(t1m);

   acx_delay #(.W(WV), .DEPTH(8)) u_dl_h00  (.clock, .en, .d(h00s), .q(h00_q11));
   acx_delay #(.W(WV), .DEPTH(7)) u_dl_dh00 (.clock, .en, .d(dh00), .q(dh00_q11));
   acx_delay #(.W(WV), .DEPTH(5)) u_dl_d2h00 (.clock, .en, .d(d2s), .q(d2h00_q11));
   acx_delay #(.W(WV), .DEPTH(9)) u_dl_h01  (.clock, .en, .d(h01), .q(h01_q11));
   acx_delay #(.W(WV), .DEPTH(5)) u_dl_dh01 (.clock, .en, .d(dh01), .q(dh01_q11));
   acx_delay #(.W(WV), .DEPTH(6)) u_dl_t1   (.clock, .en, .d(t1), .q(t1_q10));

   assign o_hd = acx_pkg::emit_wv(h00_q11);
   assign o_hc = acx_pkg::emit_wv(h01_q11);
   assign o_dd = acx_pkg::emit_wv(dh00_q11);
   assign o_dc = acx_pkg::emit_wv(dh01_q11);
   assign o_2d = acx_pkg::emit_wv(d2h00_q11);
   assign o_2c = acx_pkg::emit_wv(dc_ff);

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_h_diag    = hd_o_ff;
   assign rsp_h_coup    = hc_o_ff;
   assign rsp_dh_diag   = dd_o_ff;
   assign rsp_dh_coup   = dc_o_ff;
   assign rsp_d2h_diag  = d2d_o_ff;
   assign rsp_d2h_coup  = d2c_o_ff;
   assign rsp_saturated = sat_o_ff;

   a_exp_aligned: assert property (@(posedge clock) disable iff (reset)
      e1_valid == e2_valid)
      else $error("exponential units out of step");

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_sat_clamped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |->
         (rsp_h_diag == acx_pkg::OUT_MAX || rsp_h_diag == acx_pkg::OUT_MIN ||
          rsp_h_coup == acx_pkg::OUT_MAX || rsp_h_coup == acx_pkg::OUT_MIN ||
          rsp_dh_diag == acx_pkg::OUT_MAX || rsp_dh_diag == acx_pkg::OUT_MIN ||
          rsp_dh_coup == acx_pkg::OUT_MAX || rsp_dh_coup == acx_pkg::OUT_MIN ||
          rsp_d2h_diag == acx_pkg::OUT_MAX || rsp_d2h_diag == acx_pkg::OUT_MIN ||
          rsp_d2h_coup == acx_pkg::OUT_MAX || rsp_d2h_coup == acx_pkg::OUT_MIN))
      else $error("saturation flag without a clamped value");

endmodule
